@@ rtl/core/mhpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and codes of the min-heap priority queue
// Beat formats, action and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned CNT_FIELD_W = 11;

  // action codes
  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  // status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic                          action;
    logic signed [KEY_FIELD_W-1:0] key_in;
  } mhpq_in_t;

  typedef struct packed {
    logic [1:0]                    status;
    logic signed [KEY_FIELD_W-1:0] popped_key;
    logic signed [KEY_FIELD_W-1:0] min_key;
    logic                          is_empty;
    logic [CNT_FIELD_W-1:0]        entry_count;
  } mhpq_out_t;

  // controller -> datapath
  typedef struct packed {
    logic set_full;   // refuse insert
    logic set_empty;  // refuse extract
    logic ins_start;  // append key, open hole at the tail
    logic ext_start;  // pop root, read the tail entry
    logic last_ld;    // tail entry becomes the moving key, hole at root
    logic up_rd;      // read parent (or place key at root)
    logic up_cmp;     // compare with parent, move hole up or place key
    logic dn_rd;      // read both children
    logic dn_cmp;     // compare with children, move hole down or place key
    logic out_load;   // capture result beat
  } mhpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_full;
    logic is_zero;
    logic last_one;
    logic up_top;
    logic up_stop;
    logic dn_stop;
  } mhpq_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/mhpq_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_dpath: heap datapath
// Key store, hole index, moving key, entry count, root copy and result beat.
// ----------------------------------------------------------------------------
module mhpq_dpath #(
  parameter int unsigned HEAP_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mhpq_pkg::mhpq_in_t in_data,
  input  wire mhpq_pkg::mhpq_cmd_t cmd,
  output mhpq_pkg::mhpq_sts_t     sts,
  output mhpq_pkg::mhpq_out_t     out_data
);
  import mhpq_pkg::*;

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW = AW + 2;
  localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam logic [CW-1:0] DEPTH_CNT = CW'(HEAP_DEPTH);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);

  // keys stored offset-binary so unsigned compare gives signed order
  logic [KEY_WIDTH-1:0] mem [HEAP_DEPTH];

  logic [KEY_WIDTH-1:0] rd0_r, rd1_r;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] root_r;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [KEY_WIDTH-1:0] popped_r, popped_nxt;
  mhpq_out_t            out_r;

  logic [AW-1:0]        raddr0, raddr1, waddr, parent;
  logic                 we;
  logic [KEY_WIDTH-1:0] wdata, sval, root_key, popped_key;
  logic [IW-1:0]        lidx, ridx, sidx, cnt_ext;
  logic                 l_ok, r_ok, take_l, take_r;

  assign parent  = AW'((idx_r - AW'(1)) >> 1);
  assign lidx    = {1'b0, idx_r, 1'b1};
  assign ridx    = {1'b0, idx_r, 1'b0} + IW'(2);
  assign cnt_ext = IW'(count_r);
  assign l_ok    = lidx < cnt_ext;
  assign r_ok    = ridx < cnt_ext;

  // smaller child, left wins a tie; key stays when no child is smaller
  always_comb begin
    take_l = l_ok && (rd0_r < key_r);
    sval   = take_l ? rd0_r : key_r;
    take_r = r_ok && (rd1_r < sval);
    if (take_r) begin
      sval = rd1_r;
      sidx = ridx;
    end else if (take_l) begin
      sidx = lidx;
    end else begin
      sidx = {2'b00, idx_r};
    end
  end

  always_comb begin
    raddr0 = parent;
    raddr1 = AW'(ridx);
    if (cmd.ext_start) begin
      raddr0 = AW'(count_r - CNT_ONE);
    end else if (cmd.dn_rd) begin
      raddr0 = AW'(lidx);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = key_r;
    if (cmd.up_rd && (idx_r == '0)) begin
      we = 1'b1;
    end
    if (cmd.up_cmp) begin
      we = 1'b1;
      if (rd0_r > key_r) begin
        wdata = rd0_r;
      end
    end
    if (cmd.dn_cmp) begin
      we    = 1'b1;
      wdata = sval;
    end
  end

  assign root_key   = root_r ^ KEY_SIGN;
  assign popped_key = popped_r;

  always_comb begin
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    popped_nxt = popped_r;
    if (cmd.set_full || cmd.set_empty || cmd.ins_start || cmd.ext_start) begin
      popped_nxt = '0;
      status_nxt = cmd.set_full ? STAT_FULL : (cmd.set_empty ? STAT_EMPTY : STAT_DONE);
    end
    if (cmd.ins_start) begin
      key_nxt   = KEY_WIDTH'($unsigned(in_data.key_in)) ^ KEY_SIGN;
      idx_nxt   = AW'(count_r);
      count_nxt = count_r + CNT_ONE;
    end
    if (cmd.ext_start) begin
      popped_nxt = root_key;
      count_nxt  = count_r - CNT_ONE;
    end
    if (cmd.last_ld) begin
      key_nxt = rd0_r;
      idx_nxt = '0;
    end
    if (cmd.up_cmp && (rd0_r > key_r)) begin
      idx_nxt = parent;
    end
    if (cmd.dn_cmp) begin
      idx_nxt = AW'(sidx);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    if (we && (waddr == '0)) begin
      root_r <= wdata;
    end
    if (cmd.out_load) begin
      out_r.status      <= status_r;
      out_r.popped_key  <= KEY_FIELD_W'(popped_key);
      out_r.min_key     <= (count_r == '0) ? '0 : KEY_FIELD_W'(root_key);
      out_r.is_empty    <= (count_r == '0);
      out_r.entry_count <= CNT_FIELD_W'(count_r);
    end
  end

  assign out_data     = out_r;
  assign sts.is_full  = (count_r == DEPTH_CNT);
  assign sts.is_zero  = (count_r == '0);
  assign sts.last_one = (count_r == CNT_ONE);
  assign sts.up_top   = (idx_r == '0);
  assign sts.up_stop  = !(rd0_r > key_r);
  assign sts.dn_stop  = !(take_l || take_r);

endmodule
`default_nettype wire

@@ rtl/core/mhpq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ctrl: heap sequencer
// Accepts one action, steps the sift up or down, hands off the result beat.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                action,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire mhpq_pkg::mhpq_sts_t sts,
  output mhpq_pkg::mhpq_cmd_t      cmd
);
  import mhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_INSERT) begin
            if (sts.is_full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.ins_start = 1'b1;
              state_nxt     = S_UP_RD;
            end
          end else begin
            if (sts.is_zero) begin
              cmd.set_empty = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              cmd.ext_start = 1'b1;
              state_nxt     = sts.last_one ? S_DONE : S_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        cmd.up_rd = 1'b1;
        state_nxt = sts.up_top ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_nxt  = sts.up_stop ? S_DONE : S_UP_RD;
      end
      S_LAST: begin
        cmd.last_ld = 1'b1;
        state_nxt   = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.dn_rd = 1'b1;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_nxt  = sts.dn_stop ? S_DONE : S_DN_RD;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/min_heap_priority_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit: binary min-heap priority queue
// Insert / extract-min on a fixed-depth heap of signed keys, one result beat
// per action.
// ----------------------------------------------------------------------------
// Each input beat is an insert (action 0, key_in) or an extract-min (action 1)
// and yields exactly one result beat: status (done / empty / full), the popped
// key, the minimum after the action, an empty flag and the entry count. The
// heap lives in a single memory of HEAP_DEPTH keys with one write port and two
// registered read ports; a key travels as a hole that moves one level at a
// time, by a read step and then a compare-and-write step. A refused action
// goes straight from taking the input beat to the done state. One action
// is in flight at a time; the next input beat is taken while the previous
// result still waits at the output register, and an action only stalls in
// its done state until that beat is taken. The memory needs no clear after
// reset: only the entry count is reset, and only entries below it are ever
// used.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit #(
  parameter int unsigned HEAP_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mhpq_pkg::mhpq_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mhpq_pkg::mhpq_out_t       out_data
);
  import mhpq_pkg::*;

  mhpq_cmd_t cmd;
  mhpq_sts_t sts;

  // sequencer: one state per step of the sift
  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // key store, count and result register
  mhpq_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the min-heap priority queue unit
// Sends insert and extract-min beats through the input channel, keeps a
// shadow heap that works out the reply to each accepted beat, and checks
// every result beat field by field against the oldest outstanding reply.
// ----------------------------------------------------------------------------
module tb;
  import mhpq_pkg::*;

  localparam int unsigned HEAP_SLOTS   = 1024;  // matches the unit's default depth
  localparam int unsigned STALL_PCT    = 31;    // chance of an idle cycle per side
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES = 40;    // quiet period after the last reply
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned RESET_CYCLES = 11;

  localparam logic signed [KEY_FIELD_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic signed [KEY_FIELD_W-1:0] KEY_MAX = 32'h7fff_ffff;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mhpq_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mhpq_out_t out_data;

  // Beats still to be sent, and replies owed by the unit, oldest first.
  mhpq_in_t  action_backlog[$];
  mhpq_out_t owed_replies[$];

  // Shadow copy of the heap; only slots below shadow_count are meaningful.
  logic signed [KEY_FIELD_W-1:0] shadow_heap [HEAP_SLOTS];
  int unsigned shadow_count = 0;

  // Occupancy as seen by the stimulus builder. It depends on actions alone,
  // so the fill phase knows when the heap is full without looking at keys.
  int unsigned planned_level = 0;

  int unsigned reset_count = 0;
  int unsigned beats_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned fault_count = 0;
  logic        in_taken = 1'b0;
  logic        steady_run;

  min_heap_priority_queue_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // A window in the middle of the run (it falls inside the fill phase) where
  // neither side ever idles, so back-to-back beats get exercised too.
  assign steady_run = (beats_sent >= 400) && (beats_sent < 700);

  // --------------------------------------------------------------------------
  // Shadow heap: returns the reply one action should produce and updates the
  // shadow state. Ties stop a key in both directions; on equal children the
  // left one is taken because the right one must be strictly smaller.
  // --------------------------------------------------------------------------
  function automatic mhpq_out_t heap_reply(mhpq_in_t beat);
    mhpq_out_t                     rep;
    int unsigned                   idx;
    int unsigned                   par;
    int unsigned                   lft;
    int unsigned                   rgt;
    int unsigned                   sml;
    logic signed [KEY_FIELD_W-1:0] tmp;
    bit                            settled;
    rep = '0;
    rep.status = STAT_DONE;
    if (beat.action == ACT_INSERT) begin
      if (shadow_count >= HEAP_SLOTS) begin
        rep.status = STAT_FULL;
      end else begin
        // sift up from the tail while the parent is strictly larger
        idx = shadow_count;
        shadow_heap[idx] = beat.key_in;
        settled = 1'b0;
        while (idx > 0 && !settled) begin
          par = (idx - 1) / 2;
          if (shadow_heap[par] <= shadow_heap[idx]) begin
            settled = 1'b1;
          end else begin
            tmp = shadow_heap[par];
            shadow_heap[par] = shadow_heap[idx];
            shadow_heap[idx] = tmp;
            idx = par;
          end
        end
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        rep.status = STAT_EMPTY;
      end else begin
        rep.popped_key = shadow_heap[0];
        shadow_count--;
        if (shadow_count > 0) begin
          // tail entry goes to the root, then sinks toward the smaller child
          shadow_heap[0] = shadow_heap[shadow_count];
          idx = 0;
          settled = 1'b0;
          while (!settled) begin
            lft = 2 * idx + 1;
            rgt = lft + 1;
            sml = idx;
            if (lft < shadow_count && shadow_heap[lft] < shadow_heap[sml]) sml = lft;
            if (rgt < shadow_count && shadow_heap[rgt] < shadow_heap[sml]) sml = rgt;
            if (sml == idx) begin
              settled = 1'b1;
            end else begin
              tmp = shadow_heap[sml];
              shadow_heap[sml] = shadow_heap[idx];
              shadow_heap[idx] = tmp;
              idx = sml;
            end
          end
        end
      end
    end
    rep.min_key     = (shadow_count > 0) ? shadow_heap[0] : '0;
    rep.is_empty    = (shadow_count == 0);
    rep.entry_count = shadow_count[CNT_FIELD_W-1:0];
    return rep;
  endfunction

  task automatic flag_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_reply(mhpq_out_t want, mhpq_out_t got);
    if (got.status !== want.status || got.popped_key !== want.popped_key ||
        got.min_key !== want.min_key || got.is_empty !== want.is_empty ||
        got.entry_count !== want.entry_count) begin
      flag_fault($sformatf(
        {"reply mismatch: exp st=%0d pop=%0d min=%0d empty=%0b cnt=%0d",
         " / got st=%0d pop=%0d min=%0d empty=%0b cnt=%0d"},
        want.status, want.popped_key, want.min_key, want.is_empty, want.entry_count,
        got.status, got.popped_key, got.min_key, got.is_empty, got.entry_count));
    end
  endtask

  // Key mix: a quarter from a narrow band (lots of ties), some extremes,
  // the rest full-range random so every key bit toggles.
  function automatic logic signed [KEY_FIELD_W-1:0] pick_key();
    int narrow;
    case ($urandom_range(0, 7))
      0, 1: begin
        narrow = int'($urandom_range(0, 7)) - 4;
        return narrow;
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_action(logic act, logic signed [KEY_FIELD_W-1:0] key);
    mhpq_in_t beat;
    beat.action = act;
    beat.key_in = key;
    action_backlog.push_back(beat);
    if (act == ACT_INSERT && planned_level < HEAP_SLOTS) planned_level++;
    if (act == ACT_EXTRACT && planned_level > 0) planned_level--;
  endtask

  // --------------------------------------------------------------------------
  // Driver, on the falling edge. It also owns reset: held low for the first
  // RESET_CYCLES rising edges, then released and never touched again.
  // A new beat is only presented when the slot is free (nothing valid, or
  // the current beat was taken at the last rising edge).
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (reset_count < RESET_CYCLES - 1) begin
      reset_count <= reset_count + 1;
      rst_n <= 1'b0;
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      rst_n <= 1'b1;
      if (!in_valid || in_taken) begin
        if (action_backlog.size() > 0 &&
            (steady_run || $urandom_range(0, 99) >= STALL_PCT)) begin
          in_valid <= 1'b1;
          in_data <= action_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady_run || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor, on the rising edge: checks result beats, works out the reply
  // for each accepted input beat, and runs the stall watchdog. The result
  // side is handled before the input side so a stray result beat can never
  // be matched against a reply owed for the beat taken in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          flag_fault("result beat with no reply outstanding");
        end else begin
          check_reply(owed_replies.pop_front(), out_data);
        end
      end
      if (in_valid && in_ready) begin
        owed_replies.push_back(heap_reply(in_data));
        beats_sent <= beats_sent + 1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    // Directed: extract from an empty heap, key extremes and alternating
    // bit patterns, a run of equal keys, then drain and one more empty pop.
    queue_action(ACT_EXTRACT, pick_key());
    queue_action(ACT_INSERT, '0);
    queue_action(ACT_INSERT, KEY_MIN);
    queue_action(ACT_INSERT, KEY_MAX);
    queue_action(ACT_INSERT, '1);
    queue_action(ACT_INSERT, 32'sd5);
    queue_action(ACT_INSERT, 32'sd5);
    queue_action(ACT_INSERT, 32'sd5);
    queue_action(ACT_INSERT, 32'h5555_5555);
    queue_action(ACT_INSERT, 32'haaaa_aaaa);
    repeat (9) queue_action(ACT_EXTRACT, pick_key());
    queue_action(ACT_EXTRACT, pick_key());

    // Random mix around a shallow heap, empty pops included.
    repeat (80) begin
      queue_action(($urandom_range(0, 99) < 60) ? ACT_INSERT : ACT_EXTRACT, pick_key());
    end
    // Mostly inserts until the heap is full, then inserts that must be refused.
    while (planned_level < HEAP_SLOTS) begin
      queue_action(($urandom_range(0, 99) < 95) ? ACT_INSERT : ACT_EXTRACT, pick_key());
    end
    repeat (4) queue_action(ACT_INSERT, pick_key());
    // Extract-heavy mix on a deep heap: long sift-down paths.
    repeat (130) begin
      queue_action(($urandom_range(0, 99) < 70) ? ACT_EXTRACT : ACT_INSERT, pick_key());
    end

    while (action_backlog.size() != 0 || in_valid) @(posedge clk);
    while (owed_replies.size() != 0) @(posedge clk);
    // quiet period: any late or extra result beat is caught by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_replies.size() != 0) flag_fault("replies still outstanding at end of run");

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
